// ===== design/mqsb_pkg.sv =====
// Shared types and codes for the multi-queue shared-buffer block.
// No dependencies; imported by the controller, datapath and top level.
package mqsb_pkg;

   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_POP  = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   // controller -> datapath
   typedef struct packed {
      logic capture;  // beat accepted: latch request, issue first reads
      logic lookup;   // read data back: check, take slot or read head
      logic update;   // write back links and queue pointers
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic fail;     // valid during lookup: full push or empty pop
   } dp_status_type;

endpackage

// ===== design/mqsb_ctrl.sv =====
// Sequencer for the multi-queue shared buffer: one operation at a time.
// Depends on mqsb_pkg for the command and status structs.
module mqsb_ctrl
   import mqsb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type dp_status,
   output dp_cmd_type    dp_cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOKUP,
      S_UPDATE,
      S_RESP
   } state_type;

   state_type state_ff;

   always_comb begin
      dp_cmd.capture = (state_ff == S_IDLE) && req_valid;
      dp_cmd.lookup  = (state_ff == S_LOOKUP);
      dp_cmd.update  = (state_ff == S_UPDATE);
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) state_ff <= S_LOOKUP;
            end
            S_LOOKUP: begin
               state_ff <= dp_status.fail ? S_RESP : S_UPDATE;
            end
            S_UPDATE: begin
               state_ff <= S_RESP;
            end
            S_RESP: begin
               if (rsp_ready) state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== design/mqsb_datapath.sv =====
// Datapath: slot data and link memories, queue head/tail memories, free list.
// Depends on mqsb_pkg; driven by mqsb_ctrl commands.
module mqsb_datapath
   import mqsb_pkg::*;
#(
   parameter int SLOTS  = 64,
   parameter int QUEUES = 4
)(
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          dp_cmd,
   output dp_status_type       dp_status,
   input  logic                req_func,
   input  logic [1:0]          req_queue_id,
   input  logic signed [31:0]  req_push_value,
   output logic [1:0]          rsp_status,
   output logic signed [31:0]  rsp_pop_value
);

   localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int PTR_W = $clog2(SLOTS + 1);
   localparam int QID_W = (QUEUES > 1) ? $clog2(QUEUES) : 1;
   localparam int QX_W  = (QID_W > 2) ? QID_W : 2;
   localparam logic [PTR_W-1:0] NULLP    = PTR_W'(SLOTS);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(SLOTS - 1);

   logic [31:0]      data_mem [SLOTS];
   logic [PTR_W-1:0] link_mem [SLOTS];
   logic [PTR_W-1:0] head_mem [QUEUES];
   logic [PTR_W-1:0] tail_mem [QUEUES];

   logic [QUEUES-1:0] qv_ff;        // queue pointers written since reset
   logic [PTR_W-1:0]  free_head_ff;
   logic [PTR_W-1:0]  hwm_ff;       // slots at and above this still hold reset links

   logic              func_ff;
   logic [QID_W-1:0]  qi_ff;
   logic              qok_ff;
   logic [31:0]       value_ff;
   logic              hv_ff;
   logic [PTR_W-1:0]  head_rd_ff;
   logic [PTR_W-1:0]  tail_rd_ff;
   logic [PTR_W-1:0]  link_rd_ff;
   logic [PTR_W-1:0]  link_addr_ff;
   logic [31:0]       data_rd_ff;
   logic [PTR_W-1:0]  idx_ff;
   logic [1:0]        status_ff;
   logic [31:0]       pop_value_ff;

   logic [QX_W-1:0]  q_ext;
   logic             q_ok;
   logic [PTR_W-1:0] head_eff;
   logic [PTR_W-1:0] tail_eff;
   logic [PTR_W-1:0] link_eff;
   logic             fail;

   assign q_ext = QX_W'(req_queue_id);
   assign q_ok  = {1'b0, q_ext} < (QX_W + 1)'(QUEUES);

   assign head_eff = hv_ff ? head_rd_ff : NULLP;
   assign tail_eff = hv_ff ? tail_rd_ff : NULLP;

   // unwritten slots keep the reset chain: i -> i+1, last -> null
   always_comb begin
      if (link_addr_ff >= hwm_ff) begin
         link_eff = (link_addr_ff == LAST_PTR) ? NULLP : link_addr_ff + PTR_W'(1);
      end else begin
         link_eff = link_rd_ff;
      end
   end

   always_comb begin
      if (func_ff == FUNC_PUSH) begin
         fail = !qok_ff || (free_head_ff == NULLP);
      end else begin
         fail = !qok_ff || (head_eff == NULLP);
      end
   end

   assign dp_status.fail = fail;
   assign rsp_status     = status_ff;
   assign rsp_pop_value  = pop_value_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         qv_ff        <= '0;
         free_head_ff <= '0;
         hwm_ff       <= '0;
      end else begin
         if (dp_cmd.lookup && !fail && func_ff == FUNC_PUSH) begin
            free_head_ff <= link_eff;
            if (free_head_ff == hwm_ff) hwm_ff <= hwm_ff + PTR_W'(1);
         end
         if (dp_cmd.update) begin
            if (func_ff == FUNC_PUSH) begin
               qv_ff[qi_ff] <= 1'b1;
            end else begin
               free_head_ff <= idx_ff;
            end
         end
      end
   end

   // request capture and operation results
   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         func_ff      <= req_func;
         qi_ff        <= q_ext[QID_W-1:0];
         qok_ff       <= q_ok;
         value_ff     <= req_push_value;
         hv_ff        <= qv_ff[q_ext[QID_W-1:0]];
         link_addr_ff <= free_head_ff;
      end
      if (dp_cmd.lookup) begin
         if (func_ff == FUNC_PUSH) begin
            idx_ff <= free_head_ff;
         end else begin
            idx_ff       <= head_eff;
            link_addr_ff <= head_eff;
         end
         if (fail) begin
            status_ff    <= (func_ff == FUNC_PUSH) ? STATUS_FULL : STATUS_EMPTY;
            pop_value_ff <= '0;
         end
      end
      if (dp_cmd.update) begin
         status_ff    <= STATUS_OK;
         pop_value_ff <= (func_ff == FUNC_PUSH) ? 32'd0 : data_rd_ff;
      end
   end

   // queue pointer memories
   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         head_rd_ff <= head_mem[q_ext[QID_W-1:0]];
         tail_rd_ff <= tail_mem[q_ext[QID_W-1:0]];
      end
      if (dp_cmd.update) begin
         if (func_ff == FUNC_PUSH) begin
            if (head_eff == NULLP) head_mem[qi_ff] <= idx_ff;
            tail_mem[qi_ff] <= idx_ff;
         end else begin
            head_mem[qi_ff] <= link_eff;
            if (link_eff == NULLP) tail_mem[qi_ff] <= NULLP;
         end
      end
   end

   // slot link memory: one read and one write port
   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         link_rd_ff <= link_mem[free_head_ff[AW-1:0]];
      end
      if (dp_cmd.lookup && !fail) begin
         if (func_ff == FUNC_PUSH) begin
            link_mem[free_head_ff[AW-1:0]] <= NULLP;
         end else begin
            link_rd_ff <= link_mem[head_eff[AW-1:0]];
         end
      end
      if (dp_cmd.update) begin
         if (func_ff == FUNC_PUSH) begin
            if (head_eff != NULLP) link_mem[tail_eff[AW-1:0]] <= idx_ff;
         end else begin
            link_mem[idx_ff[AW-1:0]] <= free_head_ff;
         end
      end
   end

   // slot data memory
   always_ff @(posedge clock) begin
      if (dp_cmd.lookup && !fail) begin
         if (func_ff == FUNC_PUSH) begin
            data_mem[free_head_ff[AW-1:0]] <= value_ff;
         end else begin
            data_rd_ff <= data_mem[head_eff[AW-1:0]];
         end
      end
   end

endmodule

// ===== design/multi_queue_shared_buffer.sv =====
// Top level of the multi-queue shared buffer: controller plus datapath.
// Depends on mqsb_pkg, mqsb_ctrl and mqsb_datapath.
//
// QUEUES FIFO queues share a store of SLOTS 32-bit slots, linked through a
// free list and per-queue head/tail pointers. A request is a push (take a free
// slot, store the value, append it to the queue; status full if none is free)
// or a pop (unlink the queue's head, return its value; status empty if the
// queue has none). A queue id not below QUEUES answers full or empty. One
// operation is in flight at a time. For a successful operation rsp_valid rises
// after the lookup and the write-back of the link and pointer memories; for a
// full or empty answer it rises after the lookup alone. The next request is
// taken in the cycle after the result beat. Lookup and write-back lie in
// separate states so that the link memory needs a single write port, since a
// push writes two links. No initialization pass follows reset: slots at or
// above a high-water mark read their reset link.
module multi_queue_shared_buffer
   import mqsb_pkg::*;
#(
   parameter int SLOTS  = 64,
   parameter int QUEUES = 4
)(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_func,
   input  logic [1:0]          req_queue_id,
   input  logic signed [31:0]  req_push_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_status,
   output logic signed [31:0]  rsp_pop_value
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   mqsb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   mqsb_datapath #(
      .SLOTS  (SLOTS),
      .QUEUES (QUEUES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .dp_cmd         (dp_cmd),
      .dp_status      (dp_status),
      .req_func       (req_func),
      .req_queue_id   (req_queue_id),
      .req_push_value (req_push_value),
      .rsp_status     (rsp_status),
      .rsp_pop_value  (rsp_pop_value)
   );

endmodule
